>>> src/wsd_pkg.sv
package wsd_pkg;

	localparam int unsigned LENGTH_BITS_DEF = 64;

	localparam logic [3:0] OP_CONT = 4'h0;
	localparam logic [3:0] OP_TEXT = 4'h1;
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [2:0] EXT16_LEFT = 3'd1;
	localparam logic [2:0] EXT64_LEFT = 3'd7;
	localparam logic [1:0] KEY_LAST = 2'd3;

	typedef enum logic [5:0] {
		PH_HDR0    = 6'b000001,
		PH_HDR1    = 6'b000010,
		PH_EXTLEN  = 6'b000100,
		PH_MASK    = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_IDLE    = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_start;
		logic       buffer_end;
	} item_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       has_byte;
		logic       end_of_frame;
		logic       truncated;
	} res_t;

endpackage

>>> src/wsd_parser.sv
module wsd_parser #(
	parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  wsd_pkg::item_t item,
	output logic           res_valid,
	output wsd_pkg::res_t  res
);

	wsd_pkg::phase_t phase_q, phase_d, phase_eff;
	logic [2:0]             len_left_q, len_left_d;
	logic [LENGTH_BITS-1:0] remain_q, remain_d, remain_dec;
	logic [31:0]            key_q, key_d;
	logic [1:0]             key_pos_q, key_pos_d;
	logic                   masked_q, masked_d;
	logic [6:0]             len7;
	logic [7:0]             key_byte;
	logic                   last;

	assign last = item.buffer_end;
	assign len7 = item.data_byte[6:0];
	assign remain_dec = remain_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
	assign key_byte = key_q[8*(2'd3 - key_pos_q) +: 8];
	assign phase_eff = item.buffer_start ? wsd_pkg::PH_HDR0 : phase_q;

	always_comb begin
		phase_d    = phase_q;
		len_left_d = len_left_q;
		remain_d   = remain_q;
		key_d      = key_q;
		key_pos_d  = key_pos_q;
		masked_d   = masked_q;
		res_valid  = 1'b0;
		res        = '0;
		unique case (phase_eff)
			wsd_pkg::PH_HDR0: begin
				phase_d = (item.data_byte[3:0] == wsd_pkg::OP_CONT
					|| item.data_byte[3:0] == wsd_pkg::OP_TEXT) && !last
					? wsd_pkg::PH_HDR1 : wsd_pkg::PH_IDLE;
			end
			wsd_pkg::PH_HDR1: begin
				masked_d  = item.data_byte[7];
				key_d     = '0;
				key_pos_d = '0;
				if (len7 == wsd_pkg::LEN_EXT16 || len7 == wsd_pkg::LEN_EXT64) begin
					remain_d   = '0;
					len_left_d = (len7 == wsd_pkg::LEN_EXT16)
						? wsd_pkg::EXT16_LEFT : wsd_pkg::EXT64_LEFT;
					phase_d    = last ? wsd_pkg::PH_IDLE : wsd_pkg::PH_EXTLEN;
				end else begin
					remain_d = {{(LENGTH_BITS-7){1'b0}}, len7};
					if (item.data_byte[7]) begin
						phase_d = last ? wsd_pkg::PH_IDLE : wsd_pkg::PH_MASK;
					end else if (len7 == 7'd0 || last) begin
						phase_d          = wsd_pkg::PH_IDLE;
						res_valid        = 1'b1;
						res.end_of_frame = 1'b1;
						res.truncated    = (len7 != 7'd0);
					end else begin
						phase_d = wsd_pkg::PH_PAYLOAD;
					end
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				if (remain_q[LENGTH_BITS-1 -: 8] != 8'd0) begin
					remain_d = '1;
				end else begin
					remain_d = {remain_q[LENGTH_BITS-9:0], item.data_byte};
				end
				if (len_left_q != 3'd0) begin
					len_left_d = len_left_q - 3'd1;
					if (last) begin
						phase_d = wsd_pkg::PH_IDLE;
					end
				end else if (masked_q) begin
					phase_d = last ? wsd_pkg::PH_IDLE : wsd_pkg::PH_MASK;
				end else if (remain_d == '0 || last) begin
					key_pos_d        = '0;
					phase_d          = wsd_pkg::PH_IDLE;
					res_valid        = 1'b1;
					res.end_of_frame = 1'b1;
					res.truncated    = (remain_d != '0);
				end else begin
					key_pos_d = '0;
					phase_d   = wsd_pkg::PH_PAYLOAD;
				end
			end
			wsd_pkg::PH_MASK: begin
				key_d = {key_q[23:0], item.data_byte};
				if (key_pos_q != wsd_pkg::KEY_LAST) begin
					key_pos_d = key_pos_q + 2'd1;
					if (last) begin
						phase_d = wsd_pkg::PH_IDLE;
					end
				end else begin
					key_pos_d = '0;
					if (remain_q == '0 || last) begin
						phase_d          = wsd_pkg::PH_IDLE;
						res_valid        = 1'b1;
						res.end_of_frame = 1'b1;
						res.truncated    = (remain_q != '0);
					end else begin
						phase_d = wsd_pkg::PH_PAYLOAD;
					end
				end
			end
			wsd_pkg::PH_PAYLOAD: begin
				key_pos_d        = key_pos_q + 2'd1;
				remain_d         = remain_dec;
				res_valid        = 1'b1;
				res.has_byte     = 1'b1;
				res.payload_byte = masked_q ? (item.data_byte ^ key_byte) : item.data_byte;
				if (remain_dec == '0) begin
					phase_d          = wsd_pkg::PH_IDLE;
					res.end_of_frame = 1'b1;
				end else if (last) begin
					phase_d          = wsd_pkg::PH_IDLE;
					res.end_of_frame = 1'b1;
					res.truncated    = 1'b1;
				end
			end
			default: begin
				phase_d = wsd_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wsd_pkg::PH_HDR0;
			len_left_q <= '0;
			remain_q   <= '0;
			key_q      <= '0;
			key_pos_q  <= '0;
			masked_q   <= 1'b0;
		end else if (take) begin
			phase_q    <= phase_d;
			len_left_q <= len_left_d;
			remain_q   <= remain_d;
			key_q      <= key_d;
			key_pos_q  <= key_pos_d;
			masked_q   <= masked_d;
		end
	end

endmodule

>>> src/wsd_res_queue.sv
module wsd_res_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wsd_pkg::res_t push_res,
	output logic          full,
	output logic          pop_valid,
	input  logic          pop_stall,
	output wsd_pkg::res_t pop_res
);

	wsd_pkg::res_t entry_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          pop;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop       = pop_valid && !pop_stall;
	assign pop_res   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/websocket_frame_deframer_core.sv
// Receive-side WebSocket frame parser. One byte of a received buffer enters per
// clock on the byte channel; buffer_start restarts parsing at a frame header and
// buffer_end closes the buffer. Frames with an opcode other than continuation or
// text are skipped. Payload bytes leave unmasked on the result channel, the last
// one with end_of_frame; an empty payload gives one result with has_byte low, and
// a buffer ending mid-payload closes the frame with truncated set. The block
// sustains one byte per clock while the receiver does not stall: each byte is
// held in the input register, is parsed combinationally and lands in a
// two-entry result queue, which offers the result to the receiver. With two
// results queued, a byte in the input register stalls the byte channel.
// LENGTH_BITS (16 to 64) sets the payload counter; wider extended lengths
// saturate.
module websocket_frame_deframer_core #(
	parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       buffer_start,
	input  logic       buffer_end,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] payload_byte,
	output logic       has_byte,
	output logic       end_of_frame,
	output logic       truncated
);

	wsd_pkg::item_t item_s1;
	logic           valid_s1;
	logic           queue_full;
	logic           take;
	logic           parse_valid;
	wsd_pkg::res_t  parse_res;
	wsd_pkg::res_t  out_res;

	assign take       = valid_s1 && !queue_full;
	assign byte_stall = valid_s1 && queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= '{data_byte: data_byte, buffer_start: buffer_start,
				buffer_end: buffer_end};
		end
	end

	wsd_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item_s1),
		.res_valid (parse_valid),
		.res       (parse_res)
	);

	wsd_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && parse_valid),
		.push_res  (parse_res),
		.full      (queue_full),
		.pop_valid (res_valid),
		.pop_stall (res_stall),
		.pop_res   (out_res)
	);

	assign payload_byte = out_res.payload_byte;
	assign has_byte     = out_res.has_byte;
	assign end_of_frame = out_res.end_of_frame;
	assign truncated    = out_res.truncated;

`ifndef SYNTH
	a_bare_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !has_byte |-> end_of_frame && payload_byte == 8'd0)
		else $error("bare result without end of frame");

	a_trunc_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && truncated |-> end_of_frame)
		else $error("truncated result not marked as end of frame");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a held byte");
`endif

endmodule
